[rtl/tmhc_pkg.sv]
// shared types and constants of the tracker module header check
package tmhc_pkg;

  localparam int unsigned SAMPLE_SLOTS = 15;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned AVAIL_W = 24;
  localparam int unsigned POS_W   = 21;
  localparam int unsigned TRACK_W = 16;
  localparam int unsigned BASE_W  = 23;
  localparam int unsigned MAX48_W = 22;
  localparam int unsigned SIZE_W  = 23;

  localparam int unsigned HEADER_BYTES = 512;
  localparam int unsigned ENTRY_START  = 32;
  localparam int unsigned ENTRY_BYTES  = 32;

  localparam logic STATUS_ACCEPT = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic                    first;
    logic [DATA_W-1:0]       data;
  } item_t;

  typedef struct packed {
    logic valid;
    logic reject;
  } verdict_t;

endpackage

[rtl/tmhc_in_stage.sv]
// input register that holds one item ahead of the parser
module tmhc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           move_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tmhc_pkg::item_t item_i,
  output logic           valid_o,
  output tmhc_pkg::item_t item_o
);

  logic            valid_q;
  tmhc_pkg::item_t item_q;
  logic            load;

  assign load       = !valid_q || move_i;
  assign in_stall_o = valid_q && !move_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/tmhc_parser.sv]
// per-byte header parsing: position tracking, field capture and verdicts
module tmhc_parser #(
  parameter int unsigned SAMPLE_SLOTS = tmhc_pkg::SAMPLE_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tmhc_pkg::AVAIL_W-1:0]     cfg_data_i,
  input  logic                             step_i,
  input  tmhc_pkg::item_t                  item_i,
  output tmhc_pkg::verdict_t               verdict_o,
  output logic [tmhc_pkg::BASE_W-1:0]      base_o,
  output logic [tmhc_pkg::MAX48_W-1:0]     max48_o
);

  localparam int unsigned PosW   = tmhc_pkg::POS_W;
  localparam int unsigned TrackW = tmhc_pkg::TRACK_W;
  localparam int unsigned BaseW  = tmhc_pkg::BASE_W;
  localparam int unsigned Max48W = tmhc_pkg::MAX48_W;
  localparam int unsigned AvailW = tmhc_pkg::AVAIL_W;
  localparam logic [PosW-1:0] EntryStart = PosW'(tmhc_pkg::ENTRY_START);
  localparam logic [PosW-1:0] EntryEnd   =
    PosW'(tmhc_pkg::ENTRY_START + tmhc_pkg::ENTRY_BYTES * SAMPLE_SLOTS);
  localparam logic [PosW-1:0] TrackStart = PosW'(tmhc_pkg::HEADER_BYTES);
  localparam logic [PosW-1:0] NoTrackEnd = PosW'(tmhc_pkg::HEADER_BYTES - 1);

  logic [AvailW-1:0] avail_q;
  logic [PosW-1:0]   pos_q, pos_d, pos_e;
  logic [BaseW-1:0]  base_q, base_d, base_e;
  logic [TrackW-1:0] max_q, max_d, max_e;
  logic [Max48W-1:0] max48_q, max48_d, max48_e;
  logic [TrackW-1:0] track_q, track_d, track_e;
  logic [PosW-1:0]   end_q, end_d, end_e;
  logic [7:0]        held_q, held_d, held_e;
  logic              synth_q, synth_d, synth_e;
  logic              finished_q, finished_d;

  logic              en;
  logic [7:0]        b;
  logic [TrackW-1:0] pair;
  logic [PosW-1:0]   need;
  logic              in_entries, in_tracks;
  logic              rej_short, rej_tracks, rej_loud, reject, accept;

  assign en   = step_i && (item_i.first || !finished_q);
  assign b    = item_i.data;

  always_comb begin
    pos_e   = item_i.first ? '0 : pos_q;
    base_e  = item_i.first ? BaseW'(tmhc_pkg::HEADER_BYTES) : base_q;
    max_e   = item_i.first ? '0 : max_q;
    max48_e = item_i.first ? '0 : max48_q;
    track_e = item_i.first ? '0 : track_q;
    end_e   = item_i.first ? NoTrackEnd : end_q;
    held_e  = item_i.first ? '0 : held_q;
    synth_e = item_i.first ? 1'b0 : synth_q;
  end

  assign pair       = {held_e, b};
  assign need       = {1'b0, pair, 4'b0} + PosW'(525);
  assign in_entries = (pos_e >= EntryStart) && (pos_e < EntryEnd);
  assign in_tracks  = (pos_e >= TrackStart);

  assign rej_short  = (pos_e == '0) && (avail_q < AvailW'(tmhc_pkg::HEADER_BYTES));
  assign rej_tracks = (pos_e == PosW'(31)) && ({3'b0, need} > avail_q);
  assign rej_loud   = in_entries && (pos_e[4:0] == 5'd31) && !synth_e && (b > 8'h40);
  assign reject     = rej_short || rej_tracks || rej_loud;
  assign accept     = !reject && (pos_e == end_e);

  always_comb begin
    pos_d   = pos_e + PosW'(1);
    base_d  = base_e;
    max_d   = max_e;
    max48_d = max48_e;
    track_d = track_e;
    end_d   = end_e;
    held_d  = held_e;
    synth_d = synth_e;
    if (pos_e == PosW'(29)) begin
      base_d = base_e + {9'b0, b, 6'b0};
    end else if (pos_e == PosW'(30)) begin
      held_d = b;
    end else if (pos_e == PosW'(31)) begin
      track_d = pair;
      base_d  = base_e + {3'b0, pair, 4'b0};
      end_d   = (pair == '0) ? NoTrackEnd : ({1'b0, pair, 4'b0} + PosW'(509));
    end else if (in_entries) begin
      case (pos_e[4:0])
        5'd0:    synth_d = (b == 8'hff);
        5'd24:   held_d  = b;
        5'd25: begin
          if (!synth_e) begin
            base_d = base_e + {6'b0, pair, 1'b0};
          end
        end
        default: ;
      endcase
    end else if (in_tracks) begin
      case (pos_e[1:0])
        2'd0:    held_d = b;
        2'd1: begin
          if (pair > max_e) begin
            max_d   = pair;
            max48_d = {1'b0, pair, 5'b0} + {2'b0, pair, 4'b0};
          end
        end
        default: ;
      endcase
    end
    finished_d = reject || accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q <= '0;
    end else if (cfg_we_i) begin
      avail_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      base_q     <= '0;
      max_q      <= '0;
      max48_q    <= '0;
      track_q    <= '0;
      end_q      <= '0;
      held_q     <= '0;
      synth_q    <= 1'b0;
      finished_q <= 1'b1;
    end else if (en) begin
      pos_q      <= pos_d;
      base_q     <= base_d;
      max_q      <= max_d;
      max48_q    <= max48_d;
      track_q    <= track_d;
      end_q      <= end_d;
      held_q     <= held_d;
      synth_q    <= synth_d;
      finished_q <= finished_d;
    end
  end

  assign verdict_o.valid  = en && (reject || accept);
  assign verdict_o.reject = reject;
  assign base_o           = base_q;
  assign max48_o          = max48_q;

endmodule

[rtl/tmhc_result.sv]
// verdict register and result register with the module size add
module tmhc_result (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         move_i,
  input  tmhc_pkg::verdict_t           verdict_i,
  input  logic [tmhc_pkg::BASE_W-1:0]  base_i,
  input  logic [tmhc_pkg::MAX48_W-1:0] max48_i,
  output logic                         out_valid_o,
  output logic                         status_o,
  output logic [tmhc_pkg::SIZE_W-1:0]  module_size_o
);

  localparam int unsigned SizeW = tmhc_pkg::SIZE_W;

  tmhc_pkg::verdict_t   verdict_q;
  logic                 out_valid_q;
  logic                 status_q, status_d;
  logic [SizeW-1:0]     size_q, size_d;

  assign status_d = verdict_q.reject ? tmhc_pkg::STATUS_REJECT : tmhc_pkg::STATUS_ACCEPT;
  assign size_d   = verdict_q.reject ? '0 :
                    SizeW'(base_i) + SizeW'({1'b0, max48_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (move_i) begin
      verdict_q   <= verdict_i;
      out_valid_q <= verdict_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_i && verdict_q.valid) begin
      status_q <= status_d;
      size_q   <= size_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign module_size_o = size_q;

endmodule

[rtl/tracker_module_header_check.sv]
// top level of the tracker module header check
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   in       | in_valid_i / in_stall_o     | data_byte_i, first_byte_i
//   out      | out_valid_o / out_stall_i   | status_o, module_size_o
//   cfg      | cfg_valid_i / cfg_ready_o   | bytes_available_i
//
// one item per cycle unless out_stall_i holds a valid result on out
// the pipeline is input register, parser state, verdict register, result register
// reset clears all valids and leaves no candidate open
// out_stall_i holds the whole pipeline; the input register still takes one item
module tracker_module_header_check #(
  parameter int unsigned SAMPLE_SLOTS = tmhc_pkg::SAMPLE_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmhc_pkg::AVAIL_W-1:0]  bytes_available_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tmhc_pkg::DATA_W-1:0]   data_byte_i,
  input  logic                          first_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          status_o,
  output logic [tmhc_pkg::SIZE_W-1:0]   module_size_o
);

  logic                         move;
  logic                         item_valid;
  tmhc_pkg::item_t              item_in, item;
  tmhc_pkg::verdict_t           verdict;
  logic [tmhc_pkg::BASE_W-1:0]  base;
  logic [tmhc_pkg::MAX48_W-1:0] max48;

  assign cfg_ready_o   = 1'b1;
  assign move          = !out_valid_o || !out_stall_i;
  assign item_in.first = first_byte_i;
  assign item_in.data  = data_byte_i;

  tmhc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .move_i     (move),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  tmhc_parser #(
    .SAMPLE_SLOTS (SAMPLE_SLOTS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (bytes_available_i),
    .step_i     (move && item_valid),
    .item_i     (item),
    .verdict_o  (verdict),
    .base_o     (base),
    .max48_o    (max48)
  );

  tmhc_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .move_i        (move),
    .verdict_i     (verdict),
    .base_i        (base),
    .max48_i       (max48),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .module_size_o (module_size_o)
  );

endmodule

[rtl/tmhc_checker.sv]
// port-level assertions for the tracker module header check, with its bind
module tmhc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          status_o,
  input logic [tmhc_pkg::SIZE_W-1:0]   module_size_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(module_size_o))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_reject_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tmhc_pkg::STATUS_REJECT) |-> module_size_o == '0)
    else $error("rejected item with nonzero size");

  a_accept_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tmhc_pkg::STATUS_ACCEPT) |->
      module_size_o >= tmhc_pkg::SIZE_W'(tmhc_pkg::HEADER_BYTES))
    else $error("accepted size below header length");

endmodule

bind tracker_module_header_check tmhc_checker u_tmhc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .module_size_o (module_size_o)
);
